// ===== sv/sorted_alarm_timer_queue_defines.svh =====
// Assertion macros shared by the timer queue checker.
`ifndef SORTED_ALARM_TIMER_QUEUE_DEFINES_SVH
`define SORTED_ALARM_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SATQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SATQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/satq_pkg.sv =====
// Types and constants of the sorted alarm timer queue.
package satq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// request mode codes
	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	// result kind codes
	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_ACCEPTED = 2'd1;
	localparam logic [1:0] KIND_REJECTED = 2'd2;
	localparam logic [1:0] KIND_EXPIRED  = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [15:0] delay_seconds;
		logic [7:0]  alarm_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  expired_tag;
		logic [15:0] expired_delay;
		logic        last_result;
	} rsp_t;

	// one stored alarm
	typedef struct packed {
		logic [31:0] deadline;
		logic [15:0] delay;
		logic [7:0]  tag;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
	} slot_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t ent;
	} chain_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ===== sv/satq_cell.sv =====
// One cell of the sorted chain: holds one alarm, shifts right on insert, left on pop.
module satq_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  satq_pkg::chain_cmd_t cmd,
	input  logic                 found_in,
	output logic                 found_out,
	input  satq_pkg::slot_t      prev_slot,
	input  satq_pkg::slot_t      next_slot,
	output satq_pkg::slot_t      slot
);
	import satq_pkg::*;

	logic        valid_q;
	entry_t      ent_q;
	logic [31:0] diff;
	logic        here;

	// stored deadline same or later than the new one, or cell empty
	assign diff      = ent_q.deadline - cmd.ent.deadline;
	assign here      = !valid_q || !diff[31];
	assign found_out = found_in | here;
	assign slot      = '{valid: valid_q, ent: ent_q};

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (found_in) begin
				valid_q <= prev_slot.valid;
			end else if (here) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.pop) begin
			valid_q <= next_slot.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (found_in) begin
				ent_q <= prev_slot.ent;
			end else if (here) begin
				ent_q <= cmd.ent;
			end
		end else if (cmd.pop) begin
			ent_q <= next_slot.ent;
		end
	end

endmodule

// ===== sv/sorted_alarm_timer_queue.sv =====
// Sorted alarm timer queue: a request is taken when start is high and busy low. An insert
// shows its accepted or rejected result, then each expired alarm; a tick shows its expired
// alarms or one nothing-due result; an item gives at most MAX_RESULTS results. Results
// appear one per cycle on rsp with strobe high for exactly one cycle and cannot be held
// off; last_result marks the final one, shown in the same cycle busy drops. An item
// occupies the accept cycle, in which the cell chain does the insert or the time counter
// advances for a tick, then busy cycles of one head check each, since only the head cell
// is compared against the time counter. No clearing pass follows reset.
module sorted_alarm_timer_queue #(
	parameter int DEPTH = satq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  satq_pkg::req_t req,
	output logic           busy,
	output logic           strobe,
	output satq_pkg::rsp_t rsp
);
	import satq_pkg::*;

	state_t           state_q, state_d;
	logic [31:0]      now_q, now_d;
	rsp_t             pend_q, pend_d;
	logic             pend_v_q, pend_v_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	rsp_t             rsp_q, rsp_d;
	logic             strobe_q, strobe_d;

	chain_cmd_t cmd;
	slot_t      slot_w [DEPTH+2];
	logic       found_w [DEPTH+1];
	slot_t      head;
	logic       full;
	logic [31:0] head_diff;
	logic       due;

	// cell chain, padded with empty slots at both ends
	assign slot_w[0]       = '0;
	assign slot_w[DEPTH+1] = '0;
	assign found_w[0]      = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		satq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.found_in  (found_w[i]),
			.found_out (found_w[i+1]),
			.prev_slot (slot_w[i]),
			.next_slot (slot_w[i+2]),
			.slot      (slot_w[i+1])
		);
	end

	assign head      = slot_w[1];
	assign full      = slot_w[DEPTH].valid;
	assign head_diff = head.ent.deadline - now_q;
	assign due       = head.valid && (head_diff == '0 || head_diff[31])
		&& (cnt_q < CNT_W'(MAX_RESULTS));

	// state and time registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			now_q    <= now_d;
			pend_v_q <= pend_v_d;
			cnt_q    <= cnt_d;
			strobe_q <= strobe_d;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		rsp_q  <= rsp_d;
	end

	// sequencer: insert or tick, then pop due heads one per cycle
	always_comb begin
		state_d  = state_q;
		now_d    = now_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		cnt_d    = cnt_q;
		rsp_d    = rsp_q;
		strobe_d = 1'b0;
		cmd      = '0;
		cmd.ent  = '{deadline: now_q + 32'(req.delay_seconds),
			delay: req.delay_seconds, tag: req.alarm_id};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
					if (req.mode == MODE_INSERT) begin
						cmd.ins  = !full;
						pend_d   = '{event_kind: full ? KIND_REJECTED : KIND_ACCEPTED,
							expired_tag: '0, expired_delay: '0, last_result: 1'b0};
						pend_v_d = 1'b1;
						cnt_d    = CNT_W'(1);
					end else begin
						now_d    = now_q + 32'd1;
						pend_v_d = 1'b0;
						cnt_d    = '0;
					end
				end
			end
			ST_SCAN: begin
				if (due) begin
					// previous result is not the last; head becomes pending
					cmd.pop  = 1'b1;
					strobe_d = pend_v_q;
					rsp_d    = pend_q;
					pend_d   = '{event_kind: KIND_EXPIRED, expired_tag: head.ent.tag,
						expired_delay: head.ent.delay, last_result: 1'b0};
					pend_v_d = 1'b1;
					cnt_d    = cnt_q + CNT_W'(1);
				end else begin
					strobe_d = 1'b1;
					if (pend_v_q) begin
						rsp_d             = pend_q;
						rsp_d.last_result = 1'b1;
					end else begin
						rsp_d = '{event_kind: KIND_NONE, expired_tag: '0,
							expired_delay: '0, last_result: 1'b1};
					end
					pend_v_d = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

// ===== sv/satq_check.sv =====
// Port-level checker for the sorted alarm timer queue, bound to the top level.
`include "sorted_alarm_timer_queue_defines.svh"

module satq_check (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           strobe,
	input satq_pkg::rsp_t rsp
);
	import satq_pkg::*;

	logic take;

	assign take = start && !busy;

	// an accepted request keeps the block busy in the next cycle
	`SATQ_ASSERT_NEXT(a_take_busy, take, busy, "request accepted but block not busy")

	// no result appears in the cycle right after a request is taken
	`SATQ_ASSERT_NEXT(a_take_quiet, take, !strobe, "result right after accept")

	// the final result coincides with the block going ready
	`SATQ_ASSERT_NOW(a_last_ready, strobe && rsp.last_result, !busy,
		"final result while still busy")

	// a non-final result means more are on the way
	`SATQ_ASSERT_NOW(a_more_busy, strobe && !rsp.last_result, busy,
		"non-final result while ready")

	// only expirations carry tag and delay
	`SATQ_ASSERT_NOW(a_zero_fields, strobe && rsp.event_kind != KIND_EXPIRED,
		rsp.expired_tag == '0 && rsp.expired_delay == '0,
		"nonzero tag or delay on a non-expiry result")

endmodule

bind sorted_alarm_timer_queue satq_check u_satq_check (.*);
